// ===== src/acdf_pkg.sv =====
// acdf_pkg: shared types and constants for the ascii command to dac frame block
// no dependencies; used by every module under src
package acdf_pkg;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_D     = 8'h64;
  localparam logic [7:0] CHAR_R     = 8'h72;

  localparam int VALUE_W     = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CMD_BYTE_RESET = 8'h70;
  localparam logic [3:0] SHIFT_RESET    = 4'd6;

  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_SWITCH = 1'b1;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_STOP   = 2'd2
  } parse_phase_t;

  typedef enum logic [1:0] {
    BEAT_CMD  = 2'd0,
    BEAT_HIGH = 2'd1,
    BEAT_MID  = 2'd2,
    BEAT_LOW  = 2'd3
  } beat_t;

  typedef enum logic {
    REG_CMD_BYTE = 1'b0,
    REG_SHIFT    = 1'b1
  } reg_idx_t;

  // one finished line as handed from the front to the back
  typedef struct packed {
    logic               is_switch;
    logic               sw;
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage

// ===== src/acdf_front.sv =====
// acdf_front: collects received characters into a line, parses the value and
// issues one command per terminated dac or switch line; depends on acdf_pkg
module acdf_front #(
  parameter int LINE_CHARS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_valid,
  input  logic [7:0]          rx_byte,
  input  logic [3:0]          value_shift,
  input  logic                queue_full,
  output logic                byte_ready,
  output logic                push,
  output acdf_pkg::cmd_t      cmd
);

  localparam int CNT_W = $clog2(LINE_CHARS);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_CHARS - 1);

  logic [CNT_W-1:0]             char_count_r, char_count_nxt;
  logic [7:0]                   first_char_r, first_char_nxt;
  logic [7:0]                   second_char_r, second_char_nxt;
  acdf_pkg::parse_phase_t       phase_r, phase_nxt;
  logic                         neg_r, neg_nxt;
  logic [acdf_pkg::VALUE_W-1:0] acc_r, acc_nxt;
  logic                         switch_r, switch_nxt;

  logic                         accept;
  logic                         line_end;
  logic                         is_digit;
  logic                         is_sign;
  logic                         in_digits;
  logic [acdf_pkg::VALUE_W-1:0] signed_val;
  logic [acdf_pkg::VALUE_W-1:0] shifted_val;
  logic                         is_dac;
  logic                         is_sw;

  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;
  assign line_end   = rx_byte < acdf_pkg::CHAR_SPACE;
  assign is_digit   = (rx_byte >= acdf_pkg::CHAR_ZERO) && (rx_byte <= acdf_pkg::CHAR_NINE);
  assign is_sign    = (rx_byte == acdf_pkg::CHAR_PLUS) || (rx_byte == acdf_pkg::CHAR_MINUS);
  // a non-space, non-sign character in the leading phase is handled as in the digit phase at once
  assign in_digits  = (phase_r == acdf_pkg::PH_DIGITS) ||
                      ((phase_r == acdf_pkg::PH_LEAD) && (rx_byte != acdf_pkg::CHAR_SPACE)
                       && !is_sign);

  assign signed_val  = neg_r ? (~acc_r + acdf_pkg::VALUE_W'(1)) : acc_r;
  assign shifted_val = signed_val << value_shift;

  assign is_dac = first_char_r == acdf_pkg::CHAR_D;
  assign is_sw  = (first_char_r == acdf_pkg::CHAR_R) &&
                  ((second_char_r == acdf_pkg::CHAR_ZERO) ||
                   (second_char_r == acdf_pkg::CHAR_ONE));

  always_comb begin
    char_count_nxt  = char_count_r;
    first_char_nxt  = first_char_r;
    second_char_nxt = second_char_r;
    phase_nxt       = phase_r;
    neg_nxt         = neg_r;
    acc_nxt         = acc_r;
    switch_nxt      = switch_r;
    push            = 1'b0;
    cmd.is_switch   = is_sw && !is_dac;
    cmd.sw          = is_sw ? (second_char_r == acdf_pkg::CHAR_ONE) : switch_r;
    cmd.value       = shifted_val;
    if (accept) begin
      if (line_end) begin
        push            = is_dac || is_sw;
        if (is_sw) begin
          switch_nxt = second_char_r == acdf_pkg::CHAR_ONE;
        end
        char_count_nxt  = '0;
        first_char_nxt  = '0;
        second_char_nxt = '0;
        phase_nxt       = acdf_pkg::PH_LEAD;
        neg_nxt         = 1'b0;
        acc_nxt         = '0;
      end else if (char_count_r < CNT_LIMIT) begin
        char_count_nxt = char_count_r + CNT_W'(1);
        if (char_count_r == '0) begin
          first_char_nxt = rx_byte;
        end else begin
          if (char_count_r == CNT_W'(1)) begin
            second_char_nxt = rx_byte;
          end
          if ((phase_r == acdf_pkg::PH_LEAD) && is_sign) begin
            neg_nxt   = rx_byte == acdf_pkg::CHAR_MINUS;
            phase_nxt = acdf_pkg::PH_DIGITS;
          end else if (in_digits) begin
            if (is_digit) begin
              phase_nxt = acdf_pkg::PH_DIGITS;
              acc_nxt   = (acc_r << 3) + (acc_r << 1)
                        + acdf_pkg::VALUE_W'(rx_byte - acdf_pkg::CHAR_ZERO);
            end else begin
              phase_nxt = acdf_pkg::PH_STOP;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_count_r  <= '0;
      first_char_r  <= '0;
      second_char_r <= '0;
      phase_r       <= acdf_pkg::PH_LEAD;
      neg_r         <= 1'b0;
      acc_r         <= '0;
      switch_r      <= 1'b0;
    end else begin
      char_count_r  <= char_count_nxt;
      first_char_r  <= first_char_nxt;
      second_char_r <= second_char_nxt;
      phase_r       <= phase_nxt;
      neg_r         <= neg_nxt;
      acc_r         <= acc_nxt;
      switch_r      <= switch_nxt;
    end
  end

endmodule

// ===== src/acdf_queue.sv =====
// acdf_queue: short command queue between the line front and the frame back
// depends on acdf_pkg
module acdf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  acdf_pkg::cmd_t push_cmd,
  input  logic           pop,
  output acdf_pkg::cmd_t head_cmd,
  output logic           empty,
  output logic           full
);

  localparam int PTR_W = (acdf_pkg::QUEUE_DEPTH > 1) ? $clog2(acdf_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(acdf_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(acdf_pkg::QUEUE_DEPTH - 1);

  acdf_pkg::cmd_t   slot_r [acdf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign empty    = count_r == '0;
  assign full     = count_r == CNT_W'(acdf_pkg::QUEUE_DEPTH);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== src/acdf_back.sv =====
// acdf_back: turns queued commands into result transactions, four beats for a
// dac frame and one for a switch report; depends on acdf_pkg
module acdf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  acdf_pkg::cmd_t head_cmd,
  input  logic           queue_empty,
  input  logic [7:0]     cmd_byte,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_kind,
  output logic [7:0]     out_byte,
  output logic           out_last,
  output logic           out_switch
);

  acdf_pkg::beat_t beat_r, beat_nxt;
  logic            valid_r, valid_nxt;
  logic            kind_r, kind_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic            last_r, last_nxt;
  logic            switch_r, switch_nxt;
  logic            slot_free;
  logic            issue;
  logic [7:0]      beat_byte;
  logic            beat_last;

  assign slot_free = !valid_r || out_ready;
  assign issue     = slot_free && !queue_empty;

  always_comb begin
    case (beat_r)
      acdf_pkg::BEAT_CMD:  beat_byte = cmd_byte;
      acdf_pkg::BEAT_HIGH: beat_byte = head_cmd.value[23:16];
      acdf_pkg::BEAT_MID:  beat_byte = head_cmd.value[15:8];
      acdf_pkg::BEAT_LOW:  beat_byte = head_cmd.value[7:0];
      default:             beat_byte = cmd_byte;
    endcase
    beat_last = head_cmd.is_switch || (beat_r == acdf_pkg::BEAT_LOW);
  end

  always_comb begin
    beat_nxt   = beat_r;
    valid_nxt  = valid_r && !out_ready;
    kind_nxt   = kind_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    switch_nxt = switch_r;
    pop        = 1'b0;
    if (issue) begin
      valid_nxt  = 1'b1;
      kind_nxt   = head_cmd.is_switch ? acdf_pkg::KIND_SWITCH : acdf_pkg::KIND_FRAME;
      byte_nxt   = head_cmd.is_switch ? 8'h00 : beat_byte;
      last_nxt   = beat_last;
      switch_nxt = head_cmd.sw;
      pop        = beat_last;
      beat_nxt   = beat_last ? acdf_pkg::BEAT_CMD : acdf_pkg::beat_t'(beat_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r  <= acdf_pkg::BEAT_CMD;
      valid_r <= 1'b0;
    end else begin
      beat_r  <= beat_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    byte_r   <= byte_nxt;
    last_r   <= last_nxt;
    switch_r <= switch_nxt;
  end

  assign out_valid  = valid_r;
  assign out_kind   = kind_r;
  assign out_byte   = byte_r;
  assign out_last   = last_r;
  assign out_switch = switch_r;

endmodule

// ===== src/ascii_command_to_dac_frame.sv =====
// a terminating byte is written into the command queue, and its first result
// then comes from the back end's output register; bytes are taken one per cycle
// while the two-entry command queue has room, the back end sends one result per
// cycle while out_tready is high, four for a dac line and one for a switch line
// reset: synchronous active-low rst_n clears the line, the switch, the queue
// and the output valid flag, and loads command byte 0x70 and shift 6
module ascii_command_to_dac_frame #(
  parameter int LINE_CHARS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] frame_byte, [8] switch_setting, [15:9] zero
  output logic [0:0]  out_tuser,  // [0] out_kind
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0]     cmd_byte_r;
  logic [3:0]     shift_r;
  logic           cfg_write;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  acdf_pkg::cmd_t push_cmd;
  acdf_pkg::cmd_t head_cmd;
  logic           o_kind;
  logic [7:0]     o_byte;
  logic           o_switch;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_byte_r <= acdf_pkg::CMD_BYTE_RESET;
      shift_r    <= acdf_pkg::SHIFT_RESET;
    end else if (cfg_write) begin
      case (acdf_pkg::reg_idx_t'(cfg_paddr[2]))
        acdf_pkg::REG_CMD_BYTE: cmd_byte_r <= cfg_pwdata[7:0];
        acdf_pkg::REG_SHIFT:    shift_r    <= cfg_pwdata[3:0];
        default:                cmd_byte_r <= cmd_byte_r;
      endcase
    end
  end

  always_comb begin
    case (acdf_pkg::reg_idx_t'(cfg_paddr[2]))
      acdf_pkg::REG_CMD_BYTE: cfg_prdata = {24'h0, cmd_byte_r};
      acdf_pkg::REG_SHIFT:    cfg_prdata = {28'h0, shift_r};
      default:                cfg_prdata = 32'h0;
    endcase
  end

  acdf_front #(
    .LINE_CHARS (LINE_CHARS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (in_tvalid),
    .rx_byte     (in_tdata),
    .value_shift (shift_r),
    .queue_full  (q_full),
    .byte_ready  (in_tready),
    .push        (push),
    .cmd         (push_cmd)
  );

  acdf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  acdf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_cmd    (head_cmd),
    .queue_empty (q_empty),
    .cmd_byte    (cmd_byte_r),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_kind    (o_kind),
    .out_byte    (o_byte),
    .out_last    (out_tlast),
    .out_switch  (o_switch)
  );

  assign out_tdata = {7'h00, o_switch, o_byte};
  assign out_tuser = o_kind;

endmodule

// ===== verif/ascii_command_to_dac_frame_tb.sv =====
// self-checking testbench for ascii_command_to_dac_frame: directed and random text lines,
// an in-bench line parser predicting dac frames and switch reports, apb register writes
// depends on src/acdf_pkg.sv and src/ascii_command_to_dac_frame.sv
module ascii_command_to_dac_frame_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_CHARS   = 10;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int IDLE_PCT     = 36;
  localparam int MAX_REPORTS  = 10;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_US  = 8'h1F;
  localparam logic [7:0] BYTE_TOP = 8'hFF;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
    logic       sw;
  } dac_result_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ascii_command_to_dac_frame #(.LINE_CHARS(LINE_CHARS)) i_dut (.*);

  // line parser state, mirrors the block
  int                     line_len    = 0;
  logic [7:0]             line_head   = '0;
  logic [7:0]             line_arg    = '0;
  acdf_pkg::parse_phase_t num_phase   = acdf_pkg::PH_LEAD;
  logic                   num_neg     = 1'b0;
  logic [23:0]            num_acc     = '0;
  logic                   switch_pos  = 1'b0;
  logic [7:0]             frame_cmd   = acdf_pkg::CMD_BYTE_RESET;
  logic [3:0]             frame_shift = acdf_pkg::SHIFT_RESET;

  logic [7:0]  rx_pending[$];
  dac_result_t pending_results[$];
  int          n_queued    = 0;
  int          n_accepted  = 0;
  int          mismatches  = 0;
  int          stall_count = 0;
  logic        calm        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void decode_rx_byte(logic [7:0] c);
    logic [23:0] mag;
    logic [23:0] shifted;
    if (c >= acdf_pkg::CHAR_SPACE) begin
      if (line_len < LINE_CHARS - 1) begin
        if (line_len == 0) begin
          line_head = c;
        end else begin
          if (line_len == 1) line_arg = c;
          if (num_phase == acdf_pkg::PH_LEAD &&
              (c == acdf_pkg::CHAR_PLUS || c == acdf_pkg::CHAR_MINUS)) begin
            num_neg   = (c == acdf_pkg::CHAR_MINUS);
            num_phase = acdf_pkg::PH_DIGITS;
          end else begin
            if (num_phase == acdf_pkg::PH_LEAD && c != acdf_pkg::CHAR_SPACE)
              num_phase = acdf_pkg::PH_DIGITS;
            if (num_phase == acdf_pkg::PH_DIGITS) begin
              if (c >= acdf_pkg::CHAR_ZERO && c <= acdf_pkg::CHAR_NINE) begin
                num_acc = num_acc * 24'd10 + 24'(c - acdf_pkg::CHAR_ZERO);
              end else begin
                num_phase = acdf_pkg::PH_STOP;
              end
            end
          end
        end
        line_len++;
      end
      return;
    end
    // control byte closes the line
    if (line_head == acdf_pkg::CHAR_D) begin
      mag     = num_neg ? (24'd0 - num_acc) : num_acc;
      shifted = mag << frame_shift;
      pending_results.push_back('{acdf_pkg::KIND_FRAME, frame_cmd,      1'b0, switch_pos});
      pending_results.push_back('{acdf_pkg::KIND_FRAME, shifted[23:16], 1'b0, switch_pos});
      pending_results.push_back('{acdf_pkg::KIND_FRAME, shifted[15:8],  1'b0, switch_pos});
      pending_results.push_back('{acdf_pkg::KIND_FRAME, shifted[7:0],   1'b1, switch_pos});
    end else if (line_head == acdf_pkg::CHAR_R &&
                 (line_arg == acdf_pkg::CHAR_ZERO || line_arg == acdf_pkg::CHAR_ONE)) begin
      switch_pos = (line_arg == acdf_pkg::CHAR_ONE);
      pending_results.push_back('{acdf_pkg::KIND_SWITCH, 8'h00, 1'b1, switch_pos});
    end
    line_len  = 0;
    line_head = '0;
    line_arg  = '0;
    num_phase = acdf_pkg::PH_LEAD;
    num_neg   = 1'b0;
    num_acc   = '0;
  endfunction

  function automatic void queue_rx(logic [7:0] b);
    rx_pending.push_back(b);
    n_queued++;
  endfunction

  function automatic void queue_text(string s, logic [7:0] term);
    for (int i = 0; i < s.len(); i++) queue_rx(s[i]);
    queue_rx(term);
  endfunction

  // mostly well-formed command lines with random content, plus noise
  task automatic queue_random_traffic(int n_items);
    int target;
    int pick;
    int ndig;
    target = n_queued + n_items;
    while (n_queued < target) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        queue_rx(acdf_pkg::CHAR_D);
        repeat ($urandom_range(3)) queue_rx(acdf_pkg::CHAR_SPACE);
        case ($urandom_range(2))
          0: queue_rx(acdf_pkg::CHAR_PLUS);
          1: queue_rx(acdf_pkg::CHAR_MINUS);
          default: ;
        endcase
        ndig = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(1, 5);
        repeat (ndig) queue_rx(acdf_pkg::CHAR_ZERO + 8'($urandom_range(9)));
        if ($urandom_range(3) == 0) queue_rx(8'($urandom_range(32, 255)));
        queue_rx(8'($urandom_range(31)));
      end else if (pick < 75) begin
        queue_rx(acdf_pkg::CHAR_R);
        if ($urandom_range(4) != 0) begin
          queue_rx($urandom_range(1) ? acdf_pkg::CHAR_ONE : acdf_pkg::CHAR_ZERO);
        end else begin
          queue_rx(8'($urandom_range(32, 255)));
        end
        if ($urandom_range(3) == 0) queue_rx(8'($urandom_range(32, 255)));
        queue_rx(8'($urandom_range(31)));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 12)) queue_rx(8'($urandom_range(32, 255)));
        queue_rx(8'($urandom_range(31)));
      end else begin
        // raw bytes, may break lines anywhere
        repeat ($urandom_range(1, 6)) queue_rx(8'($urandom_range(255)));
      end
    end
    queue_rx(CHAR_LF);
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(acdf_pkg::reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(4 * int'(idx));
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      acdf_pkg::REG_CMD_BYTE: frame_cmd   = val[7:0];
      acdf_pkg::REG_SHIFT:    frame_shift = val[3:0];
      default: ;
    endcase
  endtask

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_rx_byte(in_tdata);
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (rx_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= rx_pending.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    dac_result_t got;
    dac_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{out_tuser[0], out_tdata[7:0], out_tlast, out_tdata[8]};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected transaction: kind %0d byte %02h last %0d sw %0d",
                     got.kind, got.data, got.last, got.sw);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"mismatch: expected kind %0d byte %02h last %0d sw %0d, ",
                        "got kind %0d byte %02h last %0d sw %0d"},
                       want.kind, want.data, want.last, want.sw,
                       got.kind, got.data, got.last, got.sw);
          end
        end
      end
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles with no transaction on any port
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
        stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed lines with reset register values
    queue_rx(CHAR_NUL);
    queue_text("d", CHAR_US);
    queue_text("r1", CHAR_LF);
    queue_text("r0", CHAR_CR);
    queue_text("r", BYTE_TOP);
    queue_rx(CHAR_LF);
    queue_text("d -5", CHAR_LF);
    queue_text("d999999999", CHAR_LF);
    wait_idle();

    cfg_write(acdf_pkg::REG_CMD_BYTE, 32'h0000_0000);
    cfg_write(acdf_pkg::REG_SHIFT, 32'd0);
    queue_random_traffic(100);
    wait_idle();

    cfg_write(acdf_pkg::REG_CMD_BYTE, 32'h0000_00FF);
    cfg_write(acdf_pkg::REG_SHIFT, 32'd15);
    queue_random_traffic(100);
    wait_idle();

    // long stretch without any idling on either side
    cfg_write(acdf_pkg::REG_CMD_BYTE, 32'($urandom_range(255)));
    cfg_write(acdf_pkg::REG_SHIFT, 32'd14);
    calm = 1'b1;
    queue_random_traffic(100);
    wait_idle();
    calm = 1'b0;

    cfg_write(acdf_pkg::REG_CMD_BYTE, 32'($urandom_range(255)));
    cfg_write(acdf_pkg::REG_SHIFT, 32'($urandom_range(15)));
    queue_random_traffic(120);
    wait_idle();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/acdf_pkg.sv
src/acdf_front.sv
src/acdf_queue.sv
src/acdf_back.sv
src/ascii_command_to_dac_frame.sv
verif/ascii_command_to_dac_frame_tb.sv
